// ===== hw/rtl/mrg_pkg.sv =====
// Package for the mouse report generator: word types, function codes,
// register indexes and fixed widths. No dependencies.
package mrg_pkg;

  localparam int unsigned BTN_W     = 5;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned REPORT_W  = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FUNC_MOTION = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_REPORT = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME = 2'd0,
    CFG_AXIS_SWAP     = 2'd1
  } cfg_idx_t;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET  = 8'd8;
  localparam logic                  AXIS_SWAP_RESET = 1'b1;

  localparam logic signed [DELTA_W-1:0] ACC_MAX   = 16'sh7FFF;
  localparam logic signed [DELTA_W-1:0] ACC_MIN   = 16'sh8000;
  localparam logic signed [DELTA_W-1:0] CLAMP_POS = 16'sd127;
  localparam logic signed [DELTA_W-1:0] CLAMP_NEG = -16'sd127;

  typedef struct packed {
    func_t                       func;
    logic signed [DELTA_W-1:0]   delta_x;
    logic signed [DELTA_W-1:0]   delta_y;
    logic [BTN_W-1:0]            pressed_buttons;
  } in_word_t;

  typedef struct packed {
    logic [BTN_W-1:0]            buttons;
    logic signed [REPORT_W-1:0]  report_x;
    logic signed [REPORT_W-1:0]  report_y;
  } out_word_t;

  // Input register contents handed to the core.
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

endpackage

// ===== hw/rtl/mrg_in_stage.sv =====
// Input register of the mouse report generator.
// Depends on mrg_pkg for the input word and stage types.
module mrg_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrg_pkg::in_word_t in_data,
  input  logic              take,
  output mrg_pkg::stage_t   stage
);

  logic              valid_r;
  logic              valid_nxt;
  mrg_pkg::in_word_t word_r;
  logic              load;

  // Hold the word while the core cannot take it.
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.word  = word_r;

endmodule

// ===== hw/rtl/mrg_core.sv =====
// Processing core: motion accumulators, millisecond counter, button
// debounce, configuration registers and the result register. Uses mrg_pkg.
module mrg_core #(
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mrg_pkg::stage_t                     stage,
  output logic                                take,
  input  logic                                cfg_valid,
  input  logic [mrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrg_pkg::DEBOUNCE_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mrg_pkg::out_word_t                  out_data
);

  localparam int unsigned MaskBits =
    (NUM_BUTTONS < mrg_pkg::BTN_W) ? NUM_BUTTONS : mrg_pkg::BTN_W;
  localparam logic [mrg_pkg::BTN_W-1:0] BtnMask =
    mrg_pkg::BTN_W'((64'd1 << MaskBits) - 64'd1);

  logic [mrg_pkg::DEBOUNCE_W-1:0]     debounce_r;
  logic                               swap_r;

  logic [mrg_pkg::TIME_W-1:0]         time_r, time_nxt;
  logic [mrg_pkg::TIME_W-1:0]         change_r, change_nxt;
  logic [mrg_pkg::BTN_W-1:0]          raw_r, raw_nxt;
  logic [mrg_pkg::BTN_W-1:0]          stable_r, stable_nxt;
  logic signed [mrg_pkg::DELTA_W-1:0] acc_x_r, acc_x_nxt;
  logic signed [mrg_pkg::DELTA_W-1:0] acc_y_r, acc_y_nxt;

  logic                               out_valid_r, out_valid_nxt;
  mrg_pkg::out_word_t                 out_data_r;
  mrg_pkg::out_word_t                 result;
  logic                               emit;

  logic signed [mrg_pkg::DELTA_W:0]   sum_x, sum_y;
  logic signed [mrg_pkg::DELTA_W-1:0] sat_x, sat_y;
  logic signed [mrg_pkg::DELTA_W-1:0] clp_x, clp_y;
  logic [mrg_pkg::BTN_W-1:0]          raw_in;
  logic [mrg_pkg::TIME_W-1:0]         elapsed;

  mrg_pkg::in_word_t                  w;

  assign w    = stage.word;
  assign take = stage.valid && (!out_valid_r || !out_stall);

  // Configuration: writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= mrg_pkg::DEBOUNCE_RESET;
      swap_r     <= mrg_pkg::AXIS_SWAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mrg_pkg::CFG_DEBOUNCE_TIME: debounce_r <= cfg_data;
        mrg_pkg::CFG_AXIS_SWAP:     swap_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturating accumulate: overflow shows as a sign mismatch in the top bits.
  assign sum_x = {w.delta_x[mrg_pkg::DELTA_W-1], w.delta_x} +
                 {acc_x_r[mrg_pkg::DELTA_W-1], acc_x_r};
  assign sum_y = {w.delta_y[mrg_pkg::DELTA_W-1], w.delta_y} +
                 {acc_y_r[mrg_pkg::DELTA_W-1], acc_y_r};

  always_comb begin
    if (sum_x[mrg_pkg::DELTA_W] != sum_x[mrg_pkg::DELTA_W-1]) begin
      sat_x = sum_x[mrg_pkg::DELTA_W] ? mrg_pkg::ACC_MIN : mrg_pkg::ACC_MAX;
    end else begin
      sat_x = sum_x[mrg_pkg::DELTA_W-1:0];
    end
    if (sum_y[mrg_pkg::DELTA_W] != sum_y[mrg_pkg::DELTA_W-1]) begin
      sat_y = sum_y[mrg_pkg::DELTA_W] ? mrg_pkg::ACC_MIN : mrg_pkg::ACC_MAX;
    end else begin
      sat_y = sum_y[mrg_pkg::DELTA_W-1:0];
    end
  end

  always_comb begin
    if (acc_x_r > mrg_pkg::CLAMP_POS) begin
      clp_x = mrg_pkg::CLAMP_POS;
    end else if (acc_x_r < mrg_pkg::CLAMP_NEG) begin
      clp_x = mrg_pkg::CLAMP_NEG;
    end else begin
      clp_x = acc_x_r;
    end
    if (acc_y_r > mrg_pkg::CLAMP_POS) begin
      clp_y = mrg_pkg::CLAMP_POS;
    end else if (acc_y_r < mrg_pkg::CLAMP_NEG) begin
      clp_y = mrg_pkg::CLAMP_NEG;
    end else begin
      clp_y = acc_y_r;
    end
  end

  assign raw_in  = w.pressed_buttons & BtnMask;
  assign elapsed = time_r - change_r;

  always_comb begin
    time_nxt   = time_r;
    change_nxt = change_r;
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    emit       = 1'b0;
    case (w.func)
      mrg_pkg::FUNC_MOTION: begin
        acc_x_nxt = sat_x;
        acc_y_nxt = sat_y;
      end
      mrg_pkg::FUNC_TICK: begin
        time_nxt = time_r + mrg_pkg::TIME_W'(1);
      end
      mrg_pkg::FUNC_REPORT: begin
        if (raw_in != raw_r) begin
          raw_nxt    = raw_in;
          change_nxt = time_r;
        end else if (elapsed >= mrg_pkg::TIME_W'(debounce_r)) begin
          stable_nxt = raw_in;
        end
        acc_x_nxt = acc_x_r - clp_x;
        acc_y_nxt = acc_y_r - clp_y;
        emit      = (clp_x != '0) || (clp_y != '0) || (stable_nxt != '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    result.buttons  = stable_nxt;
    result.report_x = swap_r ? clp_y[mrg_pkg::REPORT_W-1:0] : clp_x[mrg_pkg::REPORT_W-1:0];
    result.report_y = swap_r ? clp_x[mrg_pkg::REPORT_W-1:0] : clp_y[mrg_pkg::REPORT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r   <= '0;
      change_r <= '0;
      raw_r    <= '0;
      stable_r <= '0;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
    end else if (take) begin
      time_r   <= time_nxt;
      change_r <= change_nxt;
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      acc_x_r  <= acc_x_nxt;
      acc_y_r  <= acc_y_nxt;
    end
  end

  // Result register: a taken item may overwrite only a word that leaves now.
  assign out_valid_nxt = take ? emit : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/mouse_report_generator.sv =====
// Top level of the mouse report generator: input register, core and checks.
// Depends on mrg_pkg, mrg_in_stage and mrg_core.
//
// Motion, tick and report words enter through in_valid/in_stall and sustain
// one word per clock unless the result register is full and stalled. Every
// word is latched into the input register at acceptance and processed from
// there once the result register is empty or being drained; a report word
// that yields a result shows it on out_data from the next rising edge after
// the core takes the word. in_stall rises only while the input register
// holds a word and the result register is full and stalled.
// Configuration writes through cfg_valid/cfg_index/cfg_data are always ready
// and take effect on the next cycle; index 0 sets the debounce time in
// milliseconds (reset 8), index 1 the axis swap (reset 1). Only the low
// NUM_BUTTONS bits of pressed_buttons, at most five, take part in debounce.
module mouse_report_generator #(
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mrg_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mrg_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrg_pkg::DEBOUNCE_W-1:0] cfg_data
);

  mrg_pkg::stage_t stage;
  logic            take;

  assign cfg_ready = 1'b1;

  mrg_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .stage    (stage)
  );

  mrg_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .take      (take),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clamped axes never reach -128.
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.report_x != 8'sh80) && (out_data.report_y != 8'sh80))
    else $error("report axis outside clamp range");

  // An empty report is never sent.
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.buttons != '0) || (out_data.report_x != '0) ||
                  (out_data.report_y != '0))
    else $error("empty report sent");

  // A new result follows a word taken by the core.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(take))
    else $error("result without a processed word");

  // Stall only while a word waits and the result side is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage.valid && out_valid && out_stall)
    else $error("input stalled without cause");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for mouse_report_generator: directed and random motion, tick and
// report words, with a built-in model of the debounce and accumulator logic.
// Depends on mrg_pkg and the mouse_report_generator RTL.
module tb_top;
  import mrg_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         LONG_HOLD    = 80;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DEBOUNCE_W-1:0] cfg_data  = '0;

  // Model of the block's state and registers.
  logic [TIME_W-1:0]         now_ms;
  logic [TIME_W-1:0]         change_ms;
  logic [BTN_W-1:0]          raw_seen;
  logic [BTN_W-1:0]          stable_btn;
  logic signed [DELTA_W-1:0] acc_x;
  logic signed [DELTA_W-1:0] acc_y;
  logic [DEBOUNCE_W-1:0]     hold_time_cur;
  logic                      swap_axes;

  in_word_t  queued_words[$];
  out_word_t pending_reports[$];
  logic      word_taken   = 1'b0;
  bit        idle_on      = 1'b1;
  int        gap_left     = 0;
  int        stall_left   = 0;
  int        hold_left    = 0;
  int        holds_asked  = 0;
  int        holds_served = 0;
  int        failures     = 0;
  int        cycles       = 0;

  mouse_report_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [DELTA_W-1:0] sat_add(logic signed [DELTA_W-1:0] a,
                                                        logic signed [DELTA_W-1:0] b);
    int sum;
    sum = int'(a) + int'(b);
    if (sum > int'(ACC_MAX)) return ACC_MAX;
    if (sum < int'(ACC_MIN)) return ACC_MIN;
    return sum[DELTA_W-1:0];
  endfunction

  function automatic int clamp_step(logic signed [DELTA_W-1:0] acc);
    if (acc > CLAMP_POS) return int'(CLAMP_POS);
    if (acc < CLAMP_NEG) return int'(CLAMP_NEG);
    return int'(acc);
  endfunction

  task automatic advance_mouse_state(input in_word_t w);
    int        sx;
    int        sy;
    out_word_t rep;
    case (w.func)
      FUNC_MOTION: begin
        acc_x = sat_add(acc_x, w.delta_x);
        acc_y = sat_add(acc_y, w.delta_y);
      end
      FUNC_TICK: now_ms = now_ms + 1'b1;
      FUNC_REPORT: begin
        if (w.pressed_buttons != raw_seen) begin
          raw_seen  = w.pressed_buttons;
          change_ms = now_ms;
        end else if (now_ms - change_ms >= TIME_W'(hold_time_cur)) begin
          stable_btn = raw_seen;
        end
        sx = clamp_step(acc_x);
        sy = clamp_step(acc_y);
        acc_x = acc_x - sx[DELTA_W-1:0];
        acc_y = acc_y - sy[DELTA_W-1:0];
        if (sx != 0 || sy != 0 || stable_btn != '0) begin
          rep.buttons  = stable_btn;
          rep.report_x = swap_axes ? sy[REPORT_W-1:0] : sx[REPORT_W-1:0];
          rep.report_y = swap_axes ? sx[REPORT_W-1:0] : sy[REPORT_W-1:0];
          pending_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endtask

  // Track registers, accepted words and results at the rising edge.
  always @(posedge clk) begin : track
    out_word_t want;
    if (!rst_n) begin
      now_ms        = '0;
      change_ms     = '0;
      raw_seen      = '0;
      stable_btn    = '0;
      acc_x         = '0;
      acc_y         = '0;
      hold_time_cur = DEBOUNCE_RESET;
      swap_axes     = AXIS_SWAP_RESET;
      word_taken <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DEBOUNCE_TIME: hold_time_cur = cfg_data;
          CFG_AXIS_SWAP:     swap_axes = cfg_data[0];
          default: ;
        endcase
      end
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) advance_mouse_state(in_data);
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("report with none expected: buttons %0h x %0d y %0d",
                 out_data.buttons, out_data.report_x, out_data.report_y);
          failures++;
        end else begin
          want = pending_reports.pop_front();
          if (out_data.buttons !== want.buttons) begin
            $error("buttons: expected %0h, got %0h", want.buttons, out_data.buttons);
            failures++;
          end
          if (out_data.report_x !== want.report_x) begin
            $error("report_x: expected %0d, got %0d", want.report_x, out_data.report_x);
            failures++;
          end
          if (out_data.report_y !== want.report_y) begin
            $error("report_y: expected %0d, got %0d", want.report_y, out_data.report_y);
            failures++;
          end
        end
      end
    end
  end

  // Sender: hold a word until taken, then advance or insert a gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_words.size() != 0) begin
        in_data  <= queued_words.pop_front();
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: short random stalls, plus long holds on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_word_t mk_word(logic [1:0] f, logic [DELTA_W-1:0] dx,
                                       logic [DELTA_W-1:0] dy, logic [BTN_W-1:0] btn);
    in_word_t w;
    w.func            = func_t'(f);
    w.delta_x         = dx;
    w.delta_y         = dy;
    w.pressed_buttons = btn;
    return w;
  endfunction

  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(0, 7))
      0, 1, 2: return DELTA_W'($urandom_range(0, 400)) - DELTA_W'(200);
      3:       return DELTA_W'($urandom_range(0, 8)) - DELTA_W'(4);
      4: begin
        case ($urandom_range(0, 3))
          0:       return ACC_MAX;
          1:       return ACC_MIN;
          2:       return DELTA_W'(128);
          default: return DELTA_W'(-128);
        endcase
      end
      default: return DELTA_W'($urandom);
    endcase
  endfunction

  task automatic push_report(logic [BTN_W-1:0] btn);
    queued_words.push_back(mk_word(FUNC_REPORT, DELTA_W'($urandom), DELTA_W'($urandom), btn));
  endtask

  // Mostly press sequences: a held mask reported between motion and tick runs.
  task automatic queue_traffic(int n);
    int               pushed;
    int               steps;
    int               run;
    int               s;
    logic [1:0]       f;
    logic [BTN_W-1:0] held;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 9) < 8) begin
        held  = ($urandom_range(0, 3) == 0) ? '0 : BTN_W'($urandom);
        steps = $urandom_range(3, 16);
        for (s = 0; s < steps; s++) begin
          case ($urandom_range(0, 3))
            0: begin
              queued_words.push_back(mk_word(FUNC_MOTION, pick_delta(), pick_delta(),
                                             BTN_W'($urandom)));
              pushed++;
            end
            1: begin
              run = $urandom_range(1, int'(hold_time_cur) / 2 + 2);
              repeat (run) begin
                queued_words.push_back(mk_word(FUNC_TICK, DELTA_W'($urandom),
                                               DELTA_W'($urandom), BTN_W'($urandom)));
              end
              pushed += run;
            end
            default: begin
              push_report(($urandom_range(0, 6) == 0) ? BTN_W'($urandom) : held);
              pushed++;
            end
          endcase
        end
      end else begin
        f = 2'($urandom);
        queued_words.push_back(mk_word(f, DELTA_W'($urandom), DELTA_W'($urandom),
                                       BTN_W'($urandom)));
        if (f != FUNC_UNUSED) pushed++;
      end
    end
  endtask

  task automatic queue_directed();
    // nothing to send right after reset
    push_report('0);
    queued_words.push_back(mk_word(FUNC_UNUSED, ACC_MAX, ACC_MIN, '1));
    // saturate both accumulators, opposite ends
    repeat (2) queued_words.push_back(mk_word(FUNC_MOTION, ACC_MAX, ACC_MIN, '0));
    push_report('0);
    push_report('1);
    repeat (7) queued_words.push_back(mk_word(FUNC_TICK, '0, '0, '0));
    push_report('1);
    queued_words.push_back(mk_word(FUNC_TICK, '1, '1, '1));
    push_report('1);
    queued_words.push_back(mk_word(FUNC_MOTION, DELTA_W'(-1), DELTA_W'(1), '0));
    push_report(BTN_W'(10));
    push_report(BTN_W'(10));
    queued_words.push_back(mk_word(FUNC_MOTION, ACC_MIN, ACC_MAX, '1));
    push_report(BTN_W'(10));
  endtask

  // Wait until every word is taken and every report has come, then let the
  // last words clear the pipeline.
  task automatic wait_drained();
    while (queued_words.size() != 0 || in_valid || pending_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DEBOUNCE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    queue_directed();
    wait_drained();

    write_reg(CFG_DEBOUNCE_TIME, '0);
    write_reg(CFG_AXIS_SWAP, '0);
    @(posedge clk);
    // zero debounce: the second equal report takes the mask
    push_report(BTN_W'(21));
    push_report(BTN_W'(21));
    push_report('0);
    push_report('0);
    queue_traffic(300);
    wait_drained();

    write_reg(CFG_DEBOUNCE_TIME, '1);
    write_reg(CFG_AXIS_SWAP, DEBOUNCE_W'(1));
    @(posedge clk);
    queue_traffic(250);
    wait_drained();

    write_reg(CFG_DEBOUNCE_TIME, DEBOUNCE_W'(3));
    write_reg(CFG_AXIS_SWAP, '0);
    @(posedge clk);
    queue_traffic(300);
    holds_asked++;
    wait_drained();

    write_reg(CFG_DEBOUNCE_TIME, DEBOUNCE_RESET);
    write_reg(CFG_AXIS_SWAP, DEBOUNCE_W'(AXIS_SWAP_RESET));
    @(posedge clk);
    queue_traffic(480);
    while (queued_words.size() > 200) @(posedge clk);
    idle_on = 1'b0;
    wait_drained();

    if (pending_reports.size() != 0) begin
      $error("%0d expected reports never arrived", pending_reports.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mrg_pkg.sv
hw/rtl/mrg_in_stage.sv
hw/rtl/mrg_core.sv
hw/rtl/mouse_report_generator.sv
tb/tb_top.sv
